// File: rtl/bhp_pkg.sv
// Shared constants, types and control program of the byte histogram block.
`timescale 1ns / 1ps

package bhp_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int SYMBOLS        = 256;
    localparam int SYM_W          = 8;
    localparam int CUR_W          = 9;
    localparam int GRP_W          = 16;
    localparam int GRP_IDX_W      = 4;
    localparam int GROUPS         = SYMBOLS / GRP_W;
    localparam int OP_W           = 2;
    localparam int OCC_W          = 16;
    localparam int SHARE_W        = 14;
    localparam int QUO_W          = 14;
    localparam int ITER_W         = $clog2(QUO_W);
    localparam int FULL_SHARE     = 10000;

    typedef enum logic [OP_W-1:0] {
        OP_COUNT = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    // sequencing of one control word
    typedef enum logic [2:0] {
        SEQ_NEXT,
        SEQ_GOTO,
        SEQ_DISPATCH,
        SEQ_SCAN,
        SEQ_LOOP,
        SEQ_EMIT
    } t_seq;

    // datapath action of one control word
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_COUNT,
        ACT_CLEAR,
        ACT_SCAN,
        ACT_MUL,
        ACT_DIV_INIT,
        ACT_DIV_STEP,
        ACT_EMIT
    } t_act;

    typedef logic [3:0] t_upc;

    localparam t_upc UP_FETCH    = 4'd0;
    localparam t_upc UP_CNT_RD   = 4'd1;
    localparam t_upc UP_CNT_WR   = 4'd2;
    localparam t_upc UP_SCAN     = 4'd3;
    localparam t_upc UP_MUL      = 4'd4;
    localparam t_upc UP_DIV_INIT = 4'd5;
    localparam t_upc UP_DIV_STEP = 4'd6;
    localparam t_upc UP_EMIT     = 4'd7;
    localparam t_upc UP_CLEAR    = 4'd8;

    typedef struct packed {
        t_seq seq;
        t_act act;
        logic in_ready;
        logic ram_scan_addr;   // RAM address from scan result instead of latched byte
        t_upc target;
    } t_uword;

    // control store
    function automatic t_uword f_urom(input t_upc pc);
        t_uword w;
        unique case (pc)
            UP_FETCH:    w = '{SEQ_DISPATCH, ACT_NONE,     1'b1, 1'b0, UP_FETCH};
            UP_CNT_RD:   w = '{SEQ_NEXT,     ACT_NONE,     1'b0, 1'b0, UP_FETCH};
            UP_CNT_WR:   w = '{SEQ_GOTO,     ACT_COUNT,    1'b0, 1'b0, UP_FETCH};
            UP_SCAN:     w = '{SEQ_SCAN,     ACT_SCAN,     1'b0, 1'b1, UP_EMIT};
            UP_MUL:      w = '{SEQ_NEXT,     ACT_MUL,      1'b0, 1'b0, UP_FETCH};
            UP_DIV_INIT: w = '{SEQ_NEXT,     ACT_DIV_INIT, 1'b0, 1'b0, UP_FETCH};
            UP_DIV_STEP: w = '{SEQ_LOOP,     ACT_DIV_STEP, 1'b0, 1'b0, UP_FETCH};
            UP_EMIT:     w = '{SEQ_EMIT,     ACT_EMIT,     1'b0, 1'b0, UP_FETCH};
            UP_CLEAR:    w = '{SEQ_GOTO,     ACT_CLEAR,    1'b0, 1'b0, UP_FETCH};
            default:     w = '{SEQ_GOTO,     ACT_NONE,     1'b0, 1'b0, UP_FETCH};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/bhp_in_if.sv
// Request channel of the byte histogram block.
`timescale 1ns / 1ps

interface bhp_in_if import bhp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [SYM_W-1:0] byte_value;

    modport source (output valid, output op, output byte_value, input ready);
    modport sink   (input valid, input op, input byte_value, output ready);
endinterface

// File: rtl/bhp_out_if.sv
// Result channel of the byte histogram block.
`timescale 1ns / 1ps

interface bhp_out_if import bhp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               entry_found;
    logic [SYM_W-1:0]   symbol;
    logic [OCC_W-1:0]   occurrences;
    logic [SHARE_W-1:0] share_hundredths;

    modport source (output valid, output entry_found, output symbol, output occurrences,
                    output share_hundredths, input ready);
    modport sink   (input valid, input entry_found, input symbol, input occurrences,
                    input share_hundredths, output ready);
endinterface

// File: rtl/byte_histogram_with_percent.sv
// Top level: byte frequency histogram with percent-share readout.
`timescale 1ns / 1ps

// Usage:
//  i_in carries requests {op, byte_value}. op COUNT adds byte_value to the
//  histogram, op CLEAR empties it and restarts the readout, op READ returns
//  the next byte value seen (ascending) on o_out; the unused op code is
//  taken and ignored. Only READ produces a result.
//  o_out carries {entry_found, symbol, occurrences, share_hundredths};
//  entry_found = 0 with all-zero fields marks the end of the readout.
//  Timing: one request is in flight at a time; i_in.ready is high only in
//  the fetch step of the control program. COUNT is a RAM read-modify-write.
//  READ scans the 16-entry groups of occupied bits from the cursor upward,
//  reads and multiplies the count, then runs the quotient loop at one bit
//  per cycle; an exhausted readout goes from the scan straight to emit.
//  Results sit in an output register, so a stalled receiver blocks only
//  the next READ at its emit step; counts and clears go on meanwhile.
//  Reset (synchronous, active low) clears occupied bits, total, cursor and
//  the output valid; the count RAM is not cleared, it is rewritten on
//  the first count of each byte after a clear.
module byte_histogram_with_percent import bhp_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bhp_in_if.sink      i_in,
    bhp_out_if.source   o_out
);
    localparam int PROD_W = COUNT_BITS + QUO_W;     // count * 10000
    localparam int NUM_W  = COUNT_BITS + 16;        // 2*count*10000 + total
    localparam int REM_W  = COUNT_BITS + 1;         // divisor is 2*total

    // sequencer
    t_upc   r_upc;
    t_upc   n_upc;
    t_uword uw;

    // histogram state
    logic [SYMBOLS-1:0]    r_occ;
    logic [COUNT_BITS-1:0] r_total;
    logic [CUR_W-1:0]      r_cursor;
    logic [SYM_W-1:0]      r_byte;

    // readout datapath
    logic                  r_found;
    logic [SYM_W-1:0]      r_sym;
    logic [COUNT_BITS-1:0] r_cnt;
    logic [PROD_W-1:0]     r_prod;
    logic [REM_W-1:0]      r_rem;
    logic [QUO_W-1:0]      r_numlo;
    logic [QUO_W-1:0]      r_quo;
    logic [ITER_W-1:0]     r_iter;

    // output register
    logic                  r_out_valid;
    logic                  r_o_found;
    logic [SYM_W-1:0]      r_o_sym;
    logic [OCC_W-1:0]      r_o_occ;
    logic [SHARE_W-1:0]    r_o_share;

    logic                  in_acc;
    logic                  out_free;
    logic [GRP_IDX_W-1:0]  grp;
    logic [GRP_IDX_W-1:0]  grp_lo;
    logic [GRP_W-1:0]      grp_bits;
    logic                  hit_raw;
    logic                  scan_hit;
    logic                  scan_end;
    logic [GRP_IDX_W-1:0]  scan_idx;
    logic [SYM_W-1:0]      scan_sym;
    logic [SYM_W-1:0]      ram_addr;
    logic [COUNT_BITS-1:0] ram_rdata;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic                  ram_we;
    logic [COUNT_BITS-1:0] total_inc;
    logic [NUM_W-1:0]      div_num;
    logic [REM_W:0]        div_trial;
    logic [REM_W:0]        div_dsr;
    logic                  div_ge;
    logic [31:0]           cnt_wide;
    logic [OCC_W-1:0]      occ_sat;
    logic [QUO_W-1:0]      share_clamp;

    assign uw       = f_urom(r_upc);
    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    assign i_in.ready             = uw.in_ready;
    assign o_out.valid            = r_out_valid;
    assign o_out.entry_found      = r_o_found;
    assign o_out.symbol           = r_o_sym;
    assign o_out.occurrences      = r_o_occ;
    assign o_out.share_hundredths = r_o_share;

    // scan one group of occupied bits per step, from the cursor upward
    assign grp      = r_cursor[SYM_W-1:GRP_IDX_W];
    assign grp_lo   = r_cursor[GRP_IDX_W-1:0];
    assign grp_bits = r_occ[{grp, GRP_IDX_W'(0)} +: GRP_W];

    always_comb begin
        hit_raw  = 1'b0;
        scan_idx = '0;
        for (int i = GRP_W - 1; i >= 0; i--) begin
            if (grp_bits[i] && (GRP_IDX_W'(i) >= grp_lo)) begin
                hit_raw  = 1'b1;
                scan_idx = GRP_IDX_W'(i);
            end
        end
    end

    assign scan_hit = !r_cursor[CUR_W-1] && hit_raw;
    assign scan_end = r_cursor[CUR_W-1] ||
                      (!hit_raw && (grp == GRP_IDX_W'(GROUPS - 1)));
    assign scan_sym = {grp, scan_idx};

    // count RAM: read in the step before the write or the multiply
    assign ram_addr  = uw.ram_scan_addr ? scan_sym : r_byte;
    assign ram_we    = (uw.act == ACT_COUNT);
    assign ram_wdata = !r_occ[r_byte] ? COUNT_BITS'(1) :
                       (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
    assign total_inc = (r_total == '1) ? r_total : r_total + 1'b1;

    bhp_ram #(
        .W     (COUNT_BITS),
        .DEPTH (SYMBOLS)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // share = (2*cnt*10000 + total) / (2*total), restoring division
    assign div_num   = NUM_W'({r_prod, 1'b0}) + NUM_W'(r_total);
    assign div_trial = {r_rem, r_numlo[QUO_W-1]};
    assign div_dsr   = (REM_W + 1)'({r_total, 1'b0});
    assign div_ge    = (div_trial >= div_dsr);

    assign cnt_wide    = 32'(r_cnt);
    assign occ_sat     = (cnt_wide > 32'(16'hFFFF)) ? OCC_W'(16'hFFFF) : cnt_wide[OCC_W-1:0];
    assign share_clamp = (r_quo > QUO_W'(FULL_SHARE)) ? QUO_W'(FULL_SHARE) : r_quo;

    // next step
    always_comb begin
        unique case (uw.seq)
            SEQ_NEXT: n_upc = r_upc + 1'b1;
            SEQ_GOTO: n_upc = uw.target;
            SEQ_DISPATCH: begin
                if (in_acc) begin
                    unique case (t_op'(i_in.op))
                        OP_COUNT: n_upc = UP_CNT_RD;
                        OP_READ:  n_upc = UP_SCAN;
                        OP_CLEAR: n_upc = UP_CLEAR;
                        default:  n_upc = UP_FETCH;
                    endcase
                end else begin
                    n_upc = UP_FETCH;
                end
            end
            SEQ_SCAN: begin
                if (scan_hit) begin
                    n_upc = r_upc + 1'b1;
                end else if (scan_end) begin
                    n_upc = uw.target;
                end else begin
                    n_upc = r_upc;
                end
            end
            SEQ_LOOP: n_upc = (r_iter != '0) ? r_upc : r_upc + 1'b1;
            SEQ_EMIT: n_upc = out_free ? uw.target : r_upc;
            default:  n_upc = UP_FETCH;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= UP_FETCH;
            r_occ       <= '0;
            r_total     <= '0;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_upc <= n_upc;
            if (uw.act == ACT_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (uw.act)
                ACT_COUNT: begin
                    r_occ[r_byte] <= 1'b1;
                    r_total       <= total_inc;
                end
                ACT_CLEAR: begin
                    r_occ    <= '0;
                    r_total  <= '0;
                    r_cursor <= '0;
                end
                ACT_SCAN: begin
                    if (scan_hit) begin
                        r_cursor <= CUR_W'(scan_sym) + CUR_W'(1);
                    end else if (!r_cursor[CUR_W-1]) begin
                        // advance to the next group; the last group rolls over to the end mark
                        r_cursor <= CUR_W'({grp, GRP_IDX_W'(0)}) + CUR_W'(GRP_W);
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_byte <= i_in.byte_value;
        end
        case (uw.act)
            ACT_SCAN: begin
                r_found <= scan_hit;
                r_sym   <= scan_sym;
            end
            ACT_MUL: begin
                r_cnt  <= ram_rdata;
                r_prod <= PROD_W'(ram_rdata) * PROD_W'(FULL_SHARE);
            end
            ACT_DIV_INIT: begin
                r_rem   <= REM_W'(div_num >> QUO_W);
                r_numlo <= div_num[QUO_W-1:0];
                r_quo   <= '0;
                r_iter  <= ITER_W'(QUO_W - 1);
            end
            ACT_DIV_STEP: begin
                r_rem   <= div_ge ? REM_W'(div_trial - div_dsr) : REM_W'(div_trial);
                r_numlo <= {r_numlo[QUO_W-2:0], 1'b0};
                r_quo   <= {r_quo[QUO_W-2:0], div_ge};
                r_iter  <= r_iter - 1'b1;
            end
            ACT_EMIT: begin
                if (out_free) begin
                    r_o_found <= r_found;
                    r_o_sym   <= r_found ? r_sym : '0;
                    r_o_occ   <= r_found ? occ_sat : '0;
                    r_o_share <= (r_found && r_total != '0) ? SHARE_W'(share_clamp) : '0;
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= CUR_W'(SYMBOLS))
        else $error("read cursor beyond end mark");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.op == OP_CLEAR) |=> ##1
            (r_total == '0 && r_cursor == '0 && r_occ == '0))
        else $error("clear request did not empty the table");

    a_found_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.entry_found) |->
            (o_out.occurrences != '0 && o_out.share_hundredths <= SHARE_W'(FULL_SHARE)))
        else $error("reported entry with zero count or share above full");

    a_end_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.entry_found) |->
            (o_out.symbol == '0 && o_out.occurrences == '0 && o_out.share_hundredths == '0))
        else $error("end-of-readout result with nonzero fields");
`endif
endmodule

// File: rtl/bhp_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module bhp_ram #(
    parameter int W     = 16,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [W-1:0]  i_wdata,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule
